// File: rtl/hslc_pkg.sv
// Package with the item types, control structs and hash helpers of the tag cache.
`timescale 1ns / 1ps

package hslc_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 24;
  localparam int unsigned SLOT_IDX_OUT_W = 5;
  localparam int unsigned HASH_W         = 64;
  localparam int unsigned LEN_W          = 32;
  localparam int unsigned STAMP_W        = 64;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'd1469598103934665603;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic                      hit;
    logic [SLOT_IDX_OUT_W-1:0] slot_index;
    logic [HASH_W-1:0]         str_hash;
    logic [LEN_W-1:0]          key_length;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } ctrl_state_e;

  typedef struct packed {
    logic accept_byte;
    logic scan_clear;
    logic rd_en;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_status_t;

  // The prime is 2^40 + 0x1B3, so the product reduces to a handful of shifted adds.
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                input logic [7:0]        b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-8){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// File: rtl/hslc_ctrl.sv
// Controller state machine that sequences byte intake, tag scan and result commit.
`timescale 1ns / 1ps

module hslc_ctrl
  import hslc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_ACCUM: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept_byte = 1'b1;
          if (in_last_i) begin
            cmd_o.scan_clear = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

endmodule

// File: rtl/hslc_datapath.sv
// Datapath with the running hash, the tag memory, the slot scan and the result register.
`timescale 1ns / 1ps

module hslc_datapath
  import hslc_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_item_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef struct packed {
    logic [HASH_W-1:0]  tag_hash;
    logic [LEN_W-1:0]   tag_length;
    logic [STAMP_W-1:0] use_stamp;
  } tag_entry_t;

  logic [HASH_W-1:0]   run_hash_q;
  logic [LEN_W-1:0]    run_len_q;
  logic [STAMP_W-1:0]  stamp_cnt_q;
  logic [SLOT_COUNT-1:0] slot_valid_q;

  tag_entry_t          mem_q [SLOT_COUNT];
  tag_entry_t          rd_entry_q;
  logic                rd_slot_valid_q;
  logic [IDX_W-1:0]    cmp_idx_q;
  logic                cmp_vld_q;
  logic [IDX_W-1:0]    scan_idx_q;

  logic                found_q;
  logic [IDX_W-1:0]    hit_idx_q;
  logic [IDX_W-1:0]    victim_idx_q;
  logic [STAMP_W-1:0]  best_stamp_q;

  logic                out_valid_q;
  out_item_t           out_item_q;

  logic [STAMP_W-1:0]  cmp_stamp;
  logic                cmp_match;
  logic [IDX_W-1:0]    target_idx;
  logic [STAMP_W-1:0]  new_stamp;
  tag_entry_t          wr_entry;

  assign cmp_stamp  = rd_slot_valid_q ? rd_entry_q.use_stamp : '0;
  assign cmp_match  = rd_slot_valid_q && (rd_entry_q.tag_hash == run_hash_q) &&
                      (rd_entry_q.tag_length == run_len_q);
  assign target_idx = found_q ? hit_idx_q : victim_idx_q;
  assign new_stamp  = stamp_cnt_q + STAMP_W'(1);

  assign wr_entry.tag_hash   = run_hash_q;
  assign wr_entry.tag_length = run_len_q;
  assign wr_entry.use_stamp  = new_stamp;

  assign status_o.scan_last = (scan_idx_q == LAST_IDX);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_hash_q   <= FNV_BASIS;
      run_len_q    <= '0;
      stamp_cnt_q  <= '0;
      slot_valid_q <= '0;
      cmp_vld_q    <= 1'b0;
      scan_idx_q   <= '0;
      found_q      <= 1'b0;
      hit_idx_q    <= '0;
      victim_idx_q <= '0;
      best_stamp_q <= '1;
      out_valid_q  <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.rd_en;

      if (cmd_i.accept_byte) begin
        run_hash_q <= fnv_step(run_hash_q, in_item_i.data_byte);
        if (run_len_q != '1) begin
          run_len_q <= run_len_q + LEN_W'(1);
        end
      end

      if (cmd_i.scan_clear) begin
        scan_idx_q   <= '0;
        found_q      <= 1'b0;
        hit_idx_q    <= '0;
        victim_idx_q <= '0;
        best_stamp_q <= '1;
      end else begin
        if (cmd_i.rd_en && !status_o.scan_last) begin
          scan_idx_q <= scan_idx_q + IDX_W'(1);
        end
        if (cmp_vld_q) begin
          if (cmp_match && !found_q) begin
            found_q   <= 1'b1;
            hit_idx_q <= cmp_idx_q;
          end
          if (cmp_stamp < best_stamp_q) begin
            best_stamp_q <= cmp_stamp;
            victim_idx_q <= cmp_idx_q;
          end
        end
      end

      if (cmd_i.commit) begin
        slot_valid_q[target_idx] <= 1'b1;
        stamp_cnt_q              <= new_stamp;
        run_hash_q               <= FNV_BASIS;
        run_len_q                <= '0;
        out_valid_q              <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_q[target_idx] <= wr_entry;
      out_item_q.hit        <= found_q;
      out_item_q.slot_index <= SLOT_IDX_OUT_W'(target_idx);
      out_item_q.str_hash   <= run_hash_q;
      out_item_q.key_length <= run_len_q;
    end
    if (cmd_i.rd_en) begin
      rd_entry_q      <= mem_q[scan_idx_q];
      rd_slot_valid_q <= slot_valid_q[scan_idx_q];
      cmp_idx_q       <= scan_idx_q;
    end
  end

endmodule

// File: rtl/hashed_string_lru_tag_cache_unit.sv
// Top level of the hashed-key LRU tag cache: controller plus datapath.
// Non-final key bytes are accepted back to back while the controller is in its intake state.
// After a final byte the input stalls while the single-port tag memory is scanned one slot per
// cycle, then through a drain state and a write state that waits for a free output register;
// the result is registered when the write state commits it.
// Reset clears valid bits, hash, length and stamp counter; tag memory contents are not cleared.
`timescale 1ns / 1ps

module hashed_string_lru_tag_cache_unit
  import hslc_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  hslc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hslc_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: tb/hashed_string_lru_tag_cache_unit_tb.sv
// Self-checking testbench for the hashed-key LRU tag cache unit with a built-in cache predictor.
`timescale 1ns / 1ps

module hashed_string_lru_tag_cache_unit_tb;
  import hslc_pkg::*;

  localparam int unsigned SLOTS        = SLOT_COUNT_DEF;
  localparam logic [HASH_W-1:0] FNV_MULT = 64'd1099511628211;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 3 * (SLOT_COUNT_DEF + 3);
  localparam int unsigned POOL_SIZE    = 32;
  localparam int unsigned POOL_KEY_MAX = 6;
  localparam int unsigned PHASE_ITEMS  = 250;
  localparam int unsigned REPORT_MAX   = 10;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  int unsigned send_idle_pct  = 23;
  int unsigned recv_idle_pct  = 51;
  int unsigned stall_cycles   = 0;
  int unsigned mismatch_count = 0;

  in_item_t  key_bytes[$];
  out_item_t pending_lookups[$];

  logic [HASH_W-1:0]  acc_hash  = FNV_BASIS;
  logic [LEN_W-1:0]   acc_len   = '0;
  logic [STAMP_W-1:0] stamp_now = '0;
  logic [HASH_W-1:0]  slot_hash  [SLOTS];
  logic [LEN_W-1:0]   slot_len   [SLOTS];
  logic               slot_live  [SLOTS];
  logic [STAMP_W-1:0] slot_stamp [SLOTS];

  logic [7:0]  pool_byte [POOL_SIZE][POOL_KEY_MAX];
  int unsigned pool_len  [POOL_SIZE];

  hashed_string_lru_tag_cache_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic hash_and_lookup(input in_item_t it);
    out_item_t res;
    int        found;
    int        victim;
    acc_hash = (acc_hash ^ {56'd0, it.data_byte}) * FNV_MULT;
    if (acc_len != '1) begin
      acc_len = acc_len + 1'b1;
    end
    if (it.last) begin
      found  = -1;
      victim = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_live[i] && slot_hash[i] == acc_hash && slot_len[i] == acc_len) begin
          found = i;
          break;
        end
        if (slot_stamp[i] < slot_stamp[victim]) begin
          victim = i;
        end
      end
      stamp_now      = stamp_now + 1'b1;
      res.str_hash   = acc_hash;
      res.key_length = acc_len;
      if (found >= 0) begin
        slot_stamp[found] = stamp_now;
        res.hit           = 1'b1;
        res.slot_index    = found[SLOT_IDX_OUT_W-1:0];
      end else begin
        slot_hash[victim]  = acc_hash;
        slot_len[victim]   = acc_len;
        slot_live[victim]  = 1'b1;
        slot_stamp[victim] = stamp_now;
        res.hit            = 1'b0;
        res.slot_index     = victim[SLOT_IDX_OUT_W-1:0];
      end
      pending_lookups.push_back(res);
      acc_hash = FNV_BASIS;
      acc_len  = '0;
    end
  endtask

  task automatic check_lookup(input out_item_t got);
    out_item_t want;
    if (pending_lookups.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
        $display("Unexpected result: hit=%0d slot=%0d hash=%h len=%0d",
                 got.hit, got.slot_index, got.str_hash, got.key_length);
      end
    end else begin
      want = pending_lookups.pop_front();
      if (got.hit !== want.hit || got.slot_index !== want.slot_index ||
          got.str_hash !== want.str_hash || got.key_length !== want.key_length) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("Mismatch: expected hit=%0d slot=%0d hash=%h len=%0d",
                   want.hit, want.slot_index, want.str_hash, want.key_length);
          $display("          actual   hit=%0d slot=%0d hash=%h len=%0d",
                   got.hit, got.slot_index, got.str_hash, got.key_length);
        end
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic is_last);
    in_item_t it;
    it.data_byte = b;
    it.last      = is_last;
    key_bytes.push_back(it);
  endtask

  // Most keys come from a small pool so that hits, refills and evictions all occur.
  task automatic add_random_keys(input int unsigned target);
    int unsigned n;
    int unsigned idx;
    int unsigned len;
    n = 0;
    while (n < target) begin
      if ($urandom_range(99) < 80) begin
        idx = $urandom_range(POOL_SIZE - 1);
        for (int j = 0; j < pool_len[idx]; j++) begin
          push_byte(pool_byte[idx][j], j == pool_len[idx] - 1);
        end
        n += pool_len[idx];
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 24) : $urandom_range(8, 1);
        for (int j = 0; j < len; j++) begin
          push_byte(8'($urandom_range(255)), j == len - 1);
        end
        n += len;
      end
    end
  endtask

  task automatic wait_sent();
    while (key_bytes.size() != 0 || in_valid_i) begin
      @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        hash_and_lookup(in_item_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (key_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= key_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_lookup(out_item_o);
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_hash[i]  = '0;
      slot_len[i]   = '0;
      slot_live[i]  = 1'b0;
      slot_stamp[i] = '0;
    end
    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_len[p] = $urandom_range(POOL_KEY_MAX, 1);
      for (int j = 0; j < POOL_KEY_MAX; j++) begin
        pool_byte[p][j] = 8'($urandom_range(255));
      end
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero and all-ones bytes, repeats for hits, and keys that differ only in length or order.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b1);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h80, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);

    add_random_keys(PHASE_ITEMS);
    wait_sent();
    send_idle_pct = 51;
    recv_idle_pct = 23;
    add_random_keys(PHASE_ITEMS);
    wait_sent();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_keys(PHASE_ITEMS);
    wait_sent();

    while (pending_lookups.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && pending_lookups.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
